// ===== src/ablru_pkg.sv =====
// Shared types and constants for the accessed-bit LRU page queue.
package ablru_pkg;

  localparam int MAX_ENTRIES   = 16;
  localparam int PAGE_BITS     = 16;
  localparam int SLOT_BITS     = $clog2(MAX_ENTRIES);
  localparam int CNT_BITS      = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_BITS      = 5;
  localparam int IN_DATA_BITS  = ((PAGE_BITS + 7) / 8) * 8;
  localparam int OUT_RAW_BITS  = PAGE_BITS + CNT_BITS;
  localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;
  localparam int PASS_BITS     = $clog2(MAX_ENTRIES);

  typedef enum logic [1:0] {
    ACT_MAP    = 2'd0,
    ACT_ACCESS = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_EVICT  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_MARK,
    CELL_SHIFT,
    CELL_SWAP,
    CELL_CLEAR
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_DONE
  } state_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t               op;
    logic [PAGE_BITS-1:0]   page;
    logic [CNT_BITS-1:0]    count;
    logic                   phase;
  } cell_ctl_t;

endpackage

// ===== src/ablru_cell.sv =====
// One queue slot: page number and accessed bit, exchanging with its neighbours.
module ablru_cell import ablru_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cell_ctl_t            ctl,
  input  logic [SLOT_BITS-1:0] slot,
  input  logic [PAGE_BITS-1:0] left_page,
  input  logic                 left_flag,
  input  logic [PAGE_BITS-1:0] right_page,
  input  logic                 right_flag,
  output logic [PAGE_BITS-1:0] cur_page,
  output logic                 cur_flag,
  output logic                 hit
);

  logic [CNT_BITS-1:0]  slot_ext;
  logic [CNT_BITS-1:0]  slot_inc;
  logic                 occupied;
  logic                 swap_right;
  logic                 swap_left;
  logic [PAGE_BITS-1:0] page_next;
  logic                 flag_next;

  assign slot_ext = CNT_BITS'(slot);
  assign slot_inc = slot_ext + CNT_BITS'(1);
  assign occupied = slot_ext < ctl.count;
  assign hit      = occupied && (cur_page == ctl.page);

  // Odd-even transposition: a pair exchanges only when an accessed page sits
  // ahead of an unaccessed one, so equal keys never cross and order is kept.
  assign swap_right = (slot[0] == ctl.phase) && cur_flag && !right_flag &&
                      (slot_inc < ctl.count);
  assign swap_left  = (slot[0] != ctl.phase) && left_flag && !cur_flag && occupied;

  always_comb begin
    page_next = cur_page;
    flag_next = cur_flag;
    case (ctl.op)
      CELL_LOAD: begin
        if (slot_ext == ctl.count) begin
          page_next = ctl.page;
          flag_next = 1'b0;
        end
      end
      CELL_MARK: begin
        if (hit) flag_next = 1'b1;
      end
      CELL_SHIFT: begin
        page_next = right_page;
        flag_next = right_flag;
      end
      CELL_SWAP: begin
        if (swap_right) begin
          page_next = right_page;
          flag_next = right_flag;
        end else if (swap_left) begin
          page_next = left_page;
          flag_next = left_flag;
        end
      end
      CELL_CLEAR: flag_next = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_page <= page_next;
    if (rst) begin
      cur_flag <= 1'b0;
    end else begin
      cur_flag <= flag_next;
    end
  end

endmodule

// ===== src/accessed_bit_lru_page_queue.sv =====
// Top level of the accessed-bit LRU page queue: controller and row of cells.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | tuser action, tdata page
//  m_      | out | m_tvalid/m_tready  | tuser status, tdata victim_page, resident_count
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_data capacity
//
// Map, access and evict act on the queue in their accepting cycle. A tick runs
// MAX_ENTRIES odd-even exchange passes through the cell row, then clears the
// accessed bits once the output register is free. A new beat is taken once
// the previous item is done and the output register is free or being drained.
// Reset empties the queue, clears all accessed bits and sets capacity to 16.
module accessed_bit_lru_page_queue import ablru_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // [15:0] page
  input  logic [1:0]               s_tuser,   // [1:0] action
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0] m_tdata,   // [15:0] victim_page, [20:16] resident_count
  output logic [1:0]               m_tuser,   // [1:0] status
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CAP_BITS-1:0]      cfg_data
);

  state_t               state, state_next;
  logic [CAP_BITS-1:0]  capacity;
  logic [CNT_BITS-1:0]  count, count_next;
  logic [PASS_BITS-1:0] pass, pass_next;
  logic [PAGE_BITS-1:0] out_page, out_page_next;
  status_t              out_status, out_status_next;
  logic [CNT_BITS-1:0]  out_count, out_count_next;
  logic                 out_load;
  logic                 out_free;
  logic                 accept;
  action_t              action;
  logic [PAGE_BITS-1:0] in_page;
  logic                 full;
  logic                 any_hit;
  cell_ctl_t            ctl;

  logic [PAGE_BITS-1:0] cell_page [MAX_ENTRIES];
  logic                 cell_flag [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_hit;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == S_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign action    = action_t'(s_tuser);
  assign in_page   = s_tdata[PAGE_BITS-1:0];
  assign cfg_ready = 1'b1;
  assign any_hit   = |cell_hit;
  assign full      = (int'(count) >= int'(capacity)) || (int'(count) >= MAX_ENTRIES);

  assign m_tdata = OUT_DATA_BITS'({out_count, out_page});
  assign m_tuser = out_status;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
      logic [PAGE_BITS-1:0] lp, rp;
      logic                 lf, rf;
      if (gi == 0) begin : g_first
        assign lp = '0;
        assign lf = 1'b0;
      end else begin : g_mid_l
        assign lp = cell_page[gi-1];
        assign lf = cell_flag[gi-1];
      end
      if (gi == MAX_ENTRIES - 1) begin : g_last
        assign rp = '0;
        assign rf = 1'b0;
      end else begin : g_mid_r
        assign rp = cell_page[gi+1];
        assign rf = cell_flag[gi+1];
      end
      ablru_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .slot       (SLOT_BITS'(gi)),
        .left_page  (lp),
        .left_flag  (lf),
        .right_page (rp),
        .right_flag (rf),
        .cur_page   (cell_page[gi]),
        .cur_flag   (cell_flag[gi]),
        .hit        (cell_hit[gi])
      );
    end
  endgenerate

  always_comb begin
    state_next      = state;
    count_next      = count;
    pass_next       = pass;
    out_load        = 1'b0;
    out_page_next   = '0;
    out_status_next = STAT_OK;
    out_count_next  = count;
    ctl.op          = CELL_HOLD;
    ctl.page        = in_page;
    ctl.count       = count;
    ctl.phase       = pass[0];
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (action)
            ACT_MAP: begin
              out_load = 1'b1;
              if (full) begin
                out_status_next = STAT_FULL;
              end else begin
                ctl.op         = CELL_LOAD;
                count_next     = count + CNT_BITS'(1);
                out_count_next = count_next;
              end
            end
            ACT_ACCESS: begin
              out_load = 1'b1;
              ctl.op   = CELL_MARK;
              if (!any_hit) out_status_next = STAT_MISS;
            end
            ACT_EVICT: begin
              out_load = 1'b1;
              if (count == '0) begin
                out_status_next = STAT_EMPTY;
              end else begin
                ctl.op         = CELL_SHIFT;
                out_page_next  = cell_page[0];
                count_next     = count - CNT_BITS'(1);
                out_count_next = count_next;
              end
            end
            ACT_TICK: begin
              pass_next  = '0;
              state_next = S_SORT;
            end
            default: ;
          endcase
        end
      end
      S_SORT: begin
        ctl.op    = CELL_SWAP;
        pass_next = pass + PASS_BITS'(1);
        if (pass == PASS_BITS'(MAX_ENTRIES - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctl.op     = CELL_CLEAR;
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      pass     <= '0;
      capacity <= CAP_BITS'(16);
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pass  <= pass_next;
      if (cfg_valid && cfg_ready) capacity <= cfg_data;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_page   <= out_page_next;
      out_status <= out_status_next;
      out_count  <= out_count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= MAX_ENTRIES)
    else $error("resident count above queue depth");

  a_tick_sorts: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_TICK) |=> (state == S_SORT && pass == '0))
    else $error("tick did not start the exchange passes");

  a_evict_dec: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_EVICT && count != '0) |=>
      (count == $past(count) - CNT_BITS'(1) && m_tvalid && m_tuser == STAT_OK))
    else $error("evict did not remove one entry");

  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_MAP && full) |=> ($stable(count) && m_tuser == STAT_FULL))
    else $error("map into a full queue changed the queue");

endmodule
